@@ sv/avt_pkg.sv @@
// Shared types and constants for the affine vertex transform.
package avt_pkg;

	// Fixed-point format and field widths.
	localparam int FRAC_BITS_DEF = 16;
	localparam int COORD_W       = 32;
	localparam int REG_W         = 64;

	// Matrix register file: two entries per register, eight registers.
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = $clog2(NUM_REGS);
	localparam int CFG_IDX_W = 4;

	// Reset contents: the identity matrix in Q16.16.
	localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000
	};

	// Load enables for the three datapath stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

@@ sv/avt_point_if.sv @@
// Input channel carrying one point per beat.
interface avt_point_if;
	logic                                valid;
	logic                                ready;
	logic signed [avt_pkg::COORD_W-1:0]  point_x;
	logic signed [avt_pkg::COORD_W-1:0]  point_y;
	logic signed [avt_pkg::COORD_W-1:0]  point_z;

	modport source (output valid, output point_x, output point_y, output point_z,
		input ready);
	modport sink (input valid, input point_x, input point_y, input point_z,
		output ready);
endinterface

@@ sv/avt_result_if.sv @@
// Output channel carrying one transformed vertex per beat.
interface avt_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [avt_pkg::COORD_W-1:0]  out_x;
	logic signed [avt_pkg::COORD_W-1:0]  out_y;
	logic signed [avt_pkg::COORD_W-1:0]  out_z;
	logic signed [avt_pkg::COORD_W-1:0]  out_w;
	logic                                saturated;

	modport source (output valid, output out_x, output out_y, output out_z,
		output out_w, output saturated, input ready);
	modport sink (input valid, input out_x, input out_y, input out_z,
		input out_w, input saturated, output ready);
endinterface

@@ sv/avt_cfg_if.sv @@
// Configuration write channel: register index and 64-bit data per beat.
interface avt_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [avt_pkg::CFG_IDX_W-1:0]     index;
	logic [avt_pkg::REG_W-1:0]         data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/avt_row.sv @@
// One matrix row: three products, shifted sum with translation, clamp.
module avt_row #(
	parameter int FRAC_BITS = avt_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  avt_pkg::stage_en_t                 en,
	input  logic signed [avt_pkg::COORD_W-1:0] px,
	input  logic signed [avt_pkg::COORD_W-1:0] py,
	input  logic signed [avt_pkg::COORD_W-1:0] pz,
	input  logic signed [avt_pkg::COORD_W-1:0] m0,
	input  logic signed [avt_pkg::COORD_W-1:0] m1,
	input  logic signed [avt_pkg::COORD_W-1:0] m2,
	input  logic signed [avt_pkg::COORD_W-1:0] m3,
	output logic signed [avt_pkg::COORD_W-1:0] value,
	output logic                               sat
);
	localparam int CW    = avt_pkg::COORD_W;
	localparam int PW    = 2 * CW;
	localparam int SH_W  = PW - FRAC_BITS;
	localparam int SUM_W = SH_W + 2;

	logic signed [PW-1:0]    prod_x_s1, prod_y_s1, prod_z_s1;
	logic signed [CW-1:0]    trans_s1;
	logic signed [SH_W-1:0]  sh_x, sh_y, sh_z;
	logic signed [SUM_W-1:0] sum_c;
	logic signed [SUM_W-1:0] sum_s2;
	logic                    ovf_c;
	logic signed [CW-1:0]    clamp_c;
	logic signed [CW-1:0]    value_s3;
	logic                    sat_s3;

	// Stage 1: full-width signed products.
	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_x_s1 <= PW'(px) * PW'(m0);
			prod_y_s1 <= PW'(py) * PW'(m1);
			prod_z_s1 <= PW'(pz) * PW'(m2);
			trans_s1  <= m3;
		end
	end

	// Dropping the low fraction bits rounds toward minus infinity.
	assign sh_x  = prod_x_s1[PW-1:FRAC_BITS];
	assign sh_y  = prod_y_s1[PW-1:FRAC_BITS];
	assign sh_z  = prod_z_s1[PW-1:FRAC_BITS];
	assign sum_c = SUM_W'(sh_x) + SUM_W'(sh_y) + SUM_W'(sh_z) + SUM_W'(trans_s1);

	// Stage 2: exact sum of the scaled products and the translation.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			sum_s2 <= sum_c;
		end
	end

	// The sum fits when every bit above bit 31 matches the sign.
	always_comb begin
		ovf_c = (sum_s2[SUM_W-1:CW-1] != '0) && (sum_s2[SUM_W-1:CW-1] != '1);
		if (!ovf_c) begin
			clamp_c = sum_s2[CW-1:0];
		end else if (sum_s2[SUM_W-1]) begin
			clamp_c = {1'b1, {(CW-1){1'b0}}};
		end else begin
			clamp_c = {1'b0, {(CW-1){1'b1}}};
		end
	end

	// Stage 3: clamped result, held for the output channel.
	always_ff @(posedge clk) begin
		if (en.s3) begin
			value_s3 <= clamp_c;
			sat_s3   <= ovf_c;
		end
	end

	assign value = value_s3;
	assign sat   = sat_s3;
endmodule

@@ sv/affine_vertex_transform.sv @@
// Top level of the affine vertex transform: matrix registers and pipeline control.
//
// Usage:
//   point  (sink): one 3D point per beat, x, y, z in signed fixed point with
//          FRAC_BITS fraction bits; w is taken as one.
//   result (source): one beat per point, out_x/out_y/out_z/out_w and a flag
//          that is set when any of the four sums was clamped to 32 bits.
//   cfg    (sink): writes one 64-bit matrix register per beat; index i selects
//          register i, indexes beyond the eighth register are ignored. Write
//          only while no point is in flight. The port is always ready.
// Timing: three register stages (products, sum, clamp); the result is read
//   from the clamp registers. One point per cycle is accepted sustained while
//   result.ready is high; the twelve 32x32 multipliers of stage one set the depth.
// Reset: clears the pipeline valid bits and loads the identity matrix.
// Stall: each stage holds while the next is full and not moving, so bubbles
//   are squeezed out and the input stays ready until all three stages are
//   full behind a stalled result; nothing is dropped or repeated.
module affine_vertex_transform #(
	parameter int FRAC_BITS = avt_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	avt_point_if.sink     point,
	avt_result_if.source  result,
	avt_cfg_if.sink       cfg
);
	localparam int CW = avt_pkg::COORD_W;

	logic [avt_pkg::REG_W-1:0] mat_q [avt_pkg::NUM_REGS];
	logic                      v_s1, v_s2, v_s3;
	logic                      rdy1, rdy2, rdy3;
	avt_pkg::stage_en_t        en;
	logic signed [CW-1:0]      row_val [4];
	logic [3:0]                row_sat;

	// Matrix registers, loaded by configuration beats.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < avt_pkg::NUM_REGS; i++) begin
				mat_q[i] <= avt_pkg::REG_RESET[i];
			end
		end else if (cfg.valid && (cfg.index < avt_pkg::CFG_IDX_W'(avt_pkg::NUM_REGS))) begin
			mat_q[cfg.index[avt_pkg::REG_IDX_W-1:0]] <= cfg.data;
		end
	end

	// Per-stage ready: a stage moves when it is empty or the next one moves.
	assign rdy3 = !v_s3 || result.ready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign point.ready = rdy1;

	assign en.s1 = point.valid && rdy1;
	assign en.s2 = v_s1 && rdy2;
	assign en.s3 = v_s2 && rdy3;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= point.valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// One datapath per matrix row.
	for (genvar r = 0; r < 4; r++) begin : g_row
		avt_row #(
			.FRAC_BITS (FRAC_BITS)
		) u_row (
			.clk   (clk),
			.en    (en),
			.px    (point.point_x),
			.py    (point.point_y),
			.pz    (point.point_z),
			.m0    (mat_q[2*r][CW-1:0]),
			.m1    (mat_q[2*r][2*CW-1:CW]),
			.m2    (mat_q[2*r+1][CW-1:0]),
			.m3    (mat_q[2*r+1][2*CW-1:CW]),
			.value (row_val[r]),
			.sat   (row_sat[r])
		);
	end

	// Output beat.
	assign result.valid     = v_s3;
	assign result.out_x     = row_val[0];
	assign result.out_y     = row_val[1];
	assign result.out_z     = row_val[2];
	assign result.out_w     = row_val[3];
	assign result.saturated = |row_sat;

	// The input only stalls when every stage holds an item.
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!point.ready |-> (v_s1 && v_s2 && v_s3))
		else $error("input stalled with a free pipeline stage");

	// An item in stage 1 advances whenever stage 2 can take it.
	a_s1_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && rdy2) |=> v_s2)
		else $error("stage 1 item lost on advance");

	// A saturated result carries at least one clamped coordinate.
	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.saturated) |->
		(result.out_x == {1'b0, {(CW-1){1'b1}}} || result.out_x == {1'b1, {(CW-1){1'b0}}} ||
		 result.out_y == {1'b0, {(CW-1){1'b1}}} || result.out_y == {1'b1, {(CW-1){1'b0}}} ||
		 result.out_z == {1'b0, {(CW-1){1'b1}}} || result.out_z == {1'b1, {(CW-1){1'b0}}} ||
		 result.out_w == {1'b0, {(CW-1){1'b1}}} || result.out_w == {1'b1, {(CW-1){1'b0}}}))
		else $error("saturation flag without a clamped coordinate");
endmodule
